// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the pair kernel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising edge, skipped while reset is held.
`define LJ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on the rising edge, also during reset.
`define LJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LJ_ASSERT(lbl, clk, rst_n, prop, msg)
`define LJ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/lj_pkg.sv =====
// Types, constants and helper functions of the pair kernel.
package lj_pkg;

  localparam int SQRT_STAGES = 33;
  localparam int DIV_STAGES  = 64;

  localparam logic [7:0] C_ONE    = 8'd1;
  localparam logic [7:0] C_SIX    = 8'd6;
  localparam logic [7:0] C_TWELVE = 8'd12;
  localparam logic [7:0] C_THIRTY = 8'd30;
  localparam logic [7:0] C_132    = 8'd132;

  localparam logic [63:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;

  localparam logic REG_WELL_DEPTH    = 1'b0;
  localparam logic REG_ZERO_DISTANCE = 1'b1;

  typedef struct packed {
    logic [63:0] prod;
    logic        clip;
  } mul_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        clip;
  } comb_t;

  typedef struct packed {
    logic [47:0] val;
    logic        clip;
  } emit_t;

  // c1*x - c2*y as sign and magnitude, each product clipped to 64 bits.
  function automatic comb_t combine(input logic [7:0] c1, input logic [63:0] x,
                                    input logic [7:0] c2, input logic [63:0] y);
    logic [71:0] p1w;
    logic [71:0] p2w;
    logic [63:0] p1;
    logic [63:0] p2;
    comb_t       r;
    p1w    = 72'(x) * 72'(c1);
    p2w    = 72'(y) * 72'(c2);
    p1     = (|p1w[71:64]) ? '1 : p1w[63:0];
    p2     = (|p2w[71:64]) ? '1 : p2w[63:0];
    r.clip = (|p1w[71:64]) | (|p2w[71:64]);
    if (p1 >= p2) begin
      r.neg = 1'b0;
      r.mag = p1 - p2;
    end else begin
      r.neg = 1'b1;
      r.mag = p2 - p1;
    end
    return r;
  endfunction

  // Saturate a scaled magnitude to 48 bits and apply the sign.
  function automatic emit_t emit(input mul_t m, input logic neg);
    logic [63:0] lim;
    logic [63:0] v;
    emit_t       r;
    lim = neg ? NEG_LIM : POS_LIM;
    if (m.clip || (m.prod > lim)) begin
      v      = lim;
      r.clip = 1'b1;
    end else begin
      v      = m.prod;
      r.clip = 1'b0;
    end
    r.val = neg ? (48'd0 - v[47:0]) : v[47:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/lj_delay.sv =====
// Enabled shift line that keeps side data aligned with the pipeline.
module lj_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[N-1];

endmodule

// ===== rtl/core/lj_mul.sv =====
// Two-stage fixed-point multiply: floor(a*b/2^32), clipped to 64 bits.
module lj_mul import lj_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output mul_t        res
);

  logic [63:0]  pp_r [4];
  logic [127:0] sum;
  mul_t         res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= 64'(a[31:0])  * 64'(b[31:0]);
      pp_r[1] <= 64'(a[31:0])  * 64'(b[63:32]);
      pp_r[2] <= 64'(a[63:32]) * 64'(b[31:0]);
      pp_r[3] <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  assign sum = {64'd0, pp_r[0]} + {32'd0, pp_r[1], 32'd0}
             + {32'd0, pp_r[2], 32'd0} + {pp_r[3], 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.clip <= |sum[127:96];
      res_r.prod <= (|sum[127:96]) ? '1 : sum[95:32];
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/lj_sqrt.sv =====
// Pipelined integer square root of a 66-bit radicand, one root bit per stage.
module lj_sqrt import lj_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [65:0] rad,
  output logic [32:0] root
);

  logic [65:0] x_r   [SQRT_STAGES];
  logic [36:0] rem_r [SQRT_STAGES];
  logic [32:0] rt_r  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [65:0] x_in;
    logic [36:0] rem_in;
    logic [32:0] rt_in;
    logic [36:0] rem_sh;
    logic [36:0] trial;

    if (s == 0) begin : g_first
      assign x_in   = rad;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_rest
      assign x_in   = x_r[s-1];
      assign rem_in = rem_r[s-1];
      assign rt_in  = rt_r[s-1];
    end

    assign rem_sh = {rem_in[34:0], x_in[65:64]};
    assign trial  = {2'b00, rt_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s] <= {x_in[63:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r[s] <= rem_sh - trial;
          rt_r[s]  <= {rt_in[31:0], 1'b1};
        end else begin
          rem_r[s] <= rem_sh;
          rt_r[s]  <= {rt_in[31:0], 1'b0};
        end
      end
    end
  end

  assign root = rt_r[SQRT_STAGES-1];

endmodule

// ===== rtl/core/lj_div.sv =====
// Pipelined restoring divider, 64-bit numerator by 33-bit divisor.
module lj_div import lj_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [63:0] quo
);

  logic [63:0] num_r [DIV_STAGES];
  logic [63:0] quo_r [DIV_STAGES];
  logic [32:0] rem_r [DIV_STAGES];
  logic [32:0] den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [63:0] num_in;
    logic [63:0] quo_in;
    logic [32:0] rem_in;
    logic [32:0] den_in;
    logic [33:0] t;
    logic [33:0] diff;
    logic        ge;

    if (s == 0) begin : g_first
      assign num_in = num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
    end

    assign t    = {rem_in, num_in[63]};
    assign diff = t - {1'b0, den_in};
    assign ge   = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= {num_in[62:0], 1'b0};
        quo_r[s] <= {quo_in[62:0], ge};
        rem_r[s] <= ge ? diff[32:0] : t[32:0];
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ===== rtl/core/lennard_jones_pair_kernel_top.sv =====
// Lennard-Jones 12-6 pair kernel: energy, force and sigma derivatives per pair.
// Throughput: one pair per cycle while no result is held; the 64-stage dividers and 33-stage root set the depth.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets epsilon and sigma to 1.0.
`include "assert_macros.svh"

module lennard_jones_pair_kernel_top import lj_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // half_energy, force_x, force_y, force_z, slope_by_sigma, curve_by_sigma (48 each)
  output logic [287:0] out_tdata,
  // saturated
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int LAT = 116;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [31:0]    eps_r;
  logic [31:0]    sigma_r;

  // Advance everything together unless the finished result is held.
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Configuration; an index outside the list is ignored by construction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r   <= 32'h0001_0000;
      sigma_r <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WELL_DEPTH:    eps_r   <= cfg_wdata;
        REG_ZERO_DISTANCE: sigma_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: separation magnitude and sign per axis.
  logic [31:0] ad_r [3];
  logic [2:0]  negd_r;

  for (genvar k = 0; k < 3; k++) begin : g_sep
    logic [32:0] d;
    logic [32:0] dabs;
    assign d    = {in_tdata[32*k+31], in_tdata[32*k +: 32]}
                - {in_tdata[32*k+127], in_tdata[32*k+96 +: 32]};
    assign dabs = d[32] ? (33'd0 - d) : d;
    always_ff @(posedge clk) begin
      if (en) begin
        ad_r[k]   <= dabs[31:0];
        negd_r[k] <= d[32];
      end
    end
  end

  // Stage 2: squares. Stage 3: r^2 in Q32.32.
  logic [63:0] sq_r [3];
  logic [65:0] r2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= 64'(ad_r[k]) * 64'(ad_r[k]);
      end
      r2_r <= 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);
    end
  end

  // Square root: distance R in Q16.16.
  logic [32:0] root;
  lj_sqrt u_sqrt (.clk(clk), .en(en), .rad(r2_r), .root(root));

  logic [95:0] ad36;
  logic        zero115;
  logic [2:0]  negd115;

  lj_delay #(.W(96), .N(35)) u_d_ad (.clk(clk), .en(en),
    .din({ad_r[2], ad_r[1], ad_r[0]}), .dout(ad36));
  lj_delay #(.W(1), .N(79)) u_d_zero (.clk(clk), .en(en),
    .din(root == 33'd0), .dout(zero115));
  lj_delay #(.W(3), .N(114)) u_d_negd (.clk(clk), .en(en),
    .din(negd_r), .dout(negd115));

  // Dividers: q = sigma/R, w = 1/R, u_k = |d_k|/R.
  logic [63:0] q100;
  logic [63:0] w100;
  logic [63:0] u100 [3];

  lj_div u_div_q (.clk(clk), .en(en), .num({sigma_r, 32'd0}), .den(root), .quo(q100));
  lj_div u_div_w (.clk(clk), .en(en), .num(64'h0001_0000_0000_0000), .den(root),
    .quo(w100));
  for (genvar k = 0; k < 3; k++) begin : g_udiv
    lj_div u_div_u (.clk(clk), .en(en), .num({ad36[32*k +: 32], 32'd0}), .den(root),
      .quo(u100[k]));
  end

  // Powers of q.
  mul_t        mq2, mq4, mq5, mq6, mq10, mq11, mq12;
  logic [63:0] q2_104, q_104, q4_106, q_108, q6_108, q4_108, q5_110;

  lj_mul u_q2 (.clk(clk), .en(en), .a(q100), .b(q100), .res(mq2));
  lj_mul u_q4 (.clk(clk), .en(en), .a(mq2.prod), .b(mq2.prod), .res(mq4));
  lj_delay #(.W(64), .N(2)) u_d_q2 (.clk(clk), .en(en), .din(mq2.prod), .dout(q2_104));
  lj_delay #(.W(64), .N(4)) u_d_q1 (.clk(clk), .en(en), .din(q100), .dout(q_104));
  lj_mul u_q5 (.clk(clk), .en(en), .a(mq4.prod), .b(q_104), .res(mq5));
  lj_mul u_q6 (.clk(clk), .en(en), .a(mq4.prod), .b(q2_104), .res(mq6));
  lj_delay #(.W(64), .N(2)) u_d_q4a (.clk(clk), .en(en), .din(mq4.prod), .dout(q4_106));
  lj_mul u_q10 (.clk(clk), .en(en), .a(mq6.prod), .b(q4_106), .res(mq10));
  lj_mul u_q12 (.clk(clk), .en(en), .a(mq6.prod), .b(mq6.prod), .res(mq12));
  lj_delay #(.W(64), .N(4)) u_d_q1b (.clk(clk), .en(en), .din(q_104), .dout(q_108));
  lj_mul u_q11 (.clk(clk), .en(en), .a(mq10.prod), .b(q_108), .res(mq11));
  lj_delay #(.W(64), .N(2)) u_d_q6 (.clk(clk), .en(en), .din(mq6.prod), .dout(q6_108));
  lj_delay #(.W(64), .N(2)) u_d_q4b (.clk(clk), .en(en), .din(q4_106), .dout(q4_108));
  lj_delay #(.W(64), .N(4)) u_d_q5 (.clk(clk), .en(en), .din(mq5.prod), .dout(q5_110));

  // Polynomial combinations for energy, force, curve and slope.
  comb_t cmb_e_r, cmb_f_r, cmb_c_r, cmb_s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cmb_e_r <= combine(C_ONE, mq12.prod, C_ONE, q6_108);
      cmb_f_r <= combine(C_SIX, q6_108, C_TWELVE, mq12.prod);
      cmb_c_r <= combine(C_132, mq10.prod, C_THIRTY, q4_108);
      cmb_s_r <= combine(C_TWELVE, mq11.prod, C_SIX, q5_110);
    end
  end

  // Scale by 1/r and the unit separation.
  logic [63:0]  w_109, w_111, me_113;
  logic [191:0] u_111;
  mul_t         maf, mc1, mc2, msl;
  mul_t         mfk [3];

  lj_delay #(.W(64), .N(9)) u_d_w9 (.clk(clk), .en(en), .din(w100), .dout(w_109));
  lj_delay #(.W(64), .N(2)) u_d_w11 (.clk(clk), .en(en), .din(w_109), .dout(w_111));
  lj_delay #(.W(192), .N(11)) u_d_u (.clk(clk), .en(en),
    .din({u100[2], u100[1], u100[0]}), .dout(u_111));
  lj_delay #(.W(64), .N(4)) u_d_me (.clk(clk), .en(en), .din(cmb_e_r.mag), .dout(me_113));

  lj_mul u_af (.clk(clk), .en(en), .a(cmb_f_r.mag), .b(w_109), .res(maf));
  lj_mul u_c1 (.clk(clk), .en(en), .a(cmb_c_r.mag), .b(w_109), .res(mc1));
  lj_mul u_c2 (.clk(clk), .en(en), .a(mc1.prod), .b(w_111), .res(mc2));
  lj_mul u_sl (.clk(clk), .en(en), .a(cmb_s_r.mag), .b(w_111), .res(msl));
  for (genvar k = 0; k < 3; k++) begin : g_force
    lj_mul u_fk (.clk(clk), .en(en), .a(maf.prod), .b(u_111[64*k +: 64]), .res(mfk[k]));
  end

  // Output scaling by 2*eps (4*eps for force).
  logic [63:0] k2, k4;
  mul_t        oe, osl, oc;
  mul_t        ofk [3];

  assign k2 = {31'd0, eps_r, 1'b0};
  assign k4 = {30'd0, eps_r, 2'b00};

  lj_mul u_oe (.clk(clk), .en(en), .a(me_113), .b(k2), .res(oe));
  lj_mul u_osl (.clk(clk), .en(en), .a(msl.prod), .b(k2), .res(osl));
  lj_mul u_oc (.clk(clk), .en(en), .a(mc2.prod), .b(k2), .res(oc));
  for (genvar k = 0; k < 3; k++) begin : g_oforce
    lj_mul u_ofk (.clk(clk), .en(en), .a(mfk[k].prod), .b(k4), .res(ofk[k]));
  end

  // Signs, aligned with the scaled outputs.
  logic neg_e115, neg_f115, neg_c115, neg_s115;

  lj_delay #(.W(3), .N(6)) u_d_neg (.clk(clk), .en(en),
    .din({cmb_e_r.neg, cmb_f_r.neg, cmb_c_r.neg}), .dout({neg_e115, neg_f115, neg_c115}));
  lj_delay #(.W(1), .N(4)) u_d_negs (.clk(clk), .en(en), .din(cmb_s_r.neg),
    .dout(neg_s115));

  // Running clip flag; hold it in step with the item it belongs to.
  logic cl102_d, cl104_d, cl106_d, cl108_d, cl109_d, cl110_d, cl111_d, cl113_d;
  logic cl104, cl106, cl108, cl109, cl110, cl111, cl113;

  lj_delay #(.W(1), .N(2)) u_c102 (.clk(clk), .en(en), .din(mq2.clip), .dout(cl102_d));
  assign cl104 = cl102_d | mq4.clip;
  lj_delay #(.W(1), .N(2)) u_c104 (.clk(clk), .en(en), .din(cl104), .dout(cl104_d));
  assign cl106 = cl104_d | mq5.clip | mq6.clip;
  lj_delay #(.W(1), .N(2)) u_c106 (.clk(clk), .en(en), .din(cl106), .dout(cl106_d));
  assign cl108 = cl106_d | mq10.clip | mq12.clip;
  lj_delay #(.W(1), .N(1)) u_c108 (.clk(clk), .en(en), .din(cl108), .dout(cl108_d));
  assign cl109 = cl108_d | cmb_e_r.clip | cmb_f_r.clip | cmb_c_r.clip;
  lj_delay #(.W(1), .N(1)) u_c109 (.clk(clk), .en(en), .din(cl109), .dout(cl109_d));
  assign cl110 = cl109_d | mq11.clip;
  lj_delay #(.W(1), .N(1)) u_c110 (.clk(clk), .en(en), .din(cl110), .dout(cl110_d));
  assign cl111 = cl110_d | cmb_s_r.clip | maf.clip | mc1.clip;
  lj_delay #(.W(1), .N(2)) u_c111 (.clk(clk), .en(en), .din(cl111), .dout(cl111_d));
  assign cl113 = cl111_d | mfk[0].clip | mfk[1].clip | mfk[2].clip | msl.clip | mc2.clip;
  lj_delay #(.W(1), .N(2)) u_c113 (.clk(clk), .en(en), .din(cl113), .dout(cl113_d));

  // Final stage: saturate, sign, and register the result; a zero distance gives zeros with the flag set.
  emit_t       ee, esl, ec;
  emit_t       efk [3];
  logic [47:0] energy_r, slope_r, curve_r;
  logic [47:0] force_r [3];
  logic        sat_r;

  assign ee  = emit(oe, neg_e115);
  assign esl = emit(osl, neg_s115);
  assign ec  = emit(oc, neg_c115);
  for (genvar k = 0; k < 3; k++) begin : g_efk
    assign efk[k] = emit(ofk[k], neg_f115 ^ negd115[k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero115) begin
        energy_r <= '0;
        slope_r  <= '0;
        curve_r  <= '0;
        for (int k = 0; k < 3; k++) begin
          force_r[k] <= '0;
        end
        sat_r <= 1'b1;
      end else begin
        energy_r <= ee.val;
        slope_r  <= esl.val;
        curve_r  <= ec.val;
        for (int k = 0; k < 3; k++) begin
          force_r[k] <= efk[k].val;
        end
        sat_r <= cl113_d | ee.clip | esl.clip | ec.clip
               | efk[0].clip | efk[1].clip | efk[2].clip;
      end
    end
  end

  assign out_tdata = {curve_r, slope_r, force_r[2], force_r[1], force_r[0], energy_r};
  assign out_tuser = sat_r;

  // A held result freezes every stage.
  `LJ_ASSERT(a_stall_freeze, clk, rst_n, !en |=> $stable(vld_r), "pipeline moved during stall")
  // An accepted request enters the first stage.
  `LJ_ASSERT(a_enter, clk, rst_n, (in_tvalid && in_tready) |=> vld_r[0], "request lost at entry")
  // A pair at zero distance returns zero values with the flag raised.
  `LJ_ASSERT(a_zero, clk, rst_n, (en && vld_r[LAT-2] && zero115) |=> (out_tuser && out_tdata == '0), "zero distance result wrong")

endmodule
